### rtl/tcw_pkg.sv
package tcw_pkg;

    // Character codes the console reacts to
    localparam logic [7:0] CH_BS         = 8'd8;
    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_LAST_PRINT = 8'd127;

    // Attribute after reset: light grey on black
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // A tab never writes more cells than this
    localparam int         TAB_MAX_CELLS = 8;
    localparam int         TAB_CNT_W     = 3;

    typedef enum logic [2:0] {
        OP_GOTO    = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_CR      = 3'd2,
        OP_BS      = 3'd3,
        OP_TAB     = 3'd4,
        OP_PRINT   = 3'd5,
        OP_IGNORE  = 3'd6
    } tcw_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    step;
        tcw_op_t op;
        logic    fin;
        logic    first;
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
        logic tab_done;
    } tcw_status_t;

endpackage

### rtl/tcw_ctrl.sv
module tcw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [7:0]         char_byte,
    input  logic               final_in_string,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t  cmd
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TAB  = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    logic    fin_reg, fin_next;
    logic    slot_free;
    logic    accept;
    tcw_op_t dec_op;

    // Decode the incoming word into a datapath operation
    always_comb
    begin
        if (action) begin
            dec_op = OP_GOTO;
        end
        else begin
            unique case (char_byte)
                CH_LF:   dec_op = OP_NEWLINE;
                CH_CR:   dec_op = OP_CR;
                CH_BS:   dec_op = OP_BS;
                CH_TAB:  dec_op = OP_TAB;
                default:
                begin
                    if (char_byte >= CH_SPACE && char_byte <= CH_LAST_PRINT)
                        dec_op = OP_PRINT;
                    else
                        dec_op = OP_IGNORE;
                end
            endcase
        end
    end

    assign slot_free = !status.out_busy;
    assign in_stall  = !((state_reg == ST_IDLE) && slot_free);
    assign accept    = in_valid && !in_stall;

    // Issue one datapath step per free output slot
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd.step   = 1'b0;
        cmd.op     = dec_op;
        cmd.fin    = final_in_string;
        cmd.first  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    cmd.step = 1'b1;
                    fin_next = final_in_string;
                    if (dec_op == OP_TAB && !status.tab_done)
                        state_next = ST_TAB;
                end
            end
            ST_TAB:
            begin
                cmd.op    = OP_TAB;
                cmd.fin   = fin_reg;
                cmd.first = 1'b0;
                if (slot_free) begin
                    cmd.step = 1'b1;
                    if (status.tab_done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

### rtl/tcw_datapath.sv
module tcw_datapath #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8,
    parameter int ROW_W    = $clog2(ROWS),
    parameter int COL_W    = $clog2(COLS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::tcw_cmd_t    cmd,
    output tcw_pkg::tcw_status_t status,
    input  logic [7:0]           char_byte,
    input  logic [ROW_W-1:0]     goto_row,
    input  logic [COL_W-1:0]     goto_col,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 cell_write,
    output logic [ROW_W-1:0]     cell_row,
    output logic [COL_W-1:0]     cell_col,
    output logic [7:0]           cell_char,
    output logic [7:0]           cell_attr,
    output logic                 cursor_update,
    output logic [ROW_W-1:0]     cursor_row,
    output logic [COL_W-1:0]     cursor_col,
    output logic                 last
);
    import tcw_pkg::*;

    localparam int                 MAX_K    = (2 ** (COL_W + 1) - 1) / TAB_STOP;
    localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]   COL_LAST = COL_W'(COLS - 1);
    localparam logic [COL_W:0]     COL_END  = (COL_W + 1)'(COLS);

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [7:0]           attr_reg, attr_next;
    logic [TAB_CNT_W-1:0] tab_cnt_reg, tab_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 wr_reg, wr_next;
    logic [ROW_W-1:0]     crow_reg, crow_next;
    logic [COL_W-1:0]     ccol_reg, ccol_next;
    logic [7:0]           cchar_reg, cchar_next;
    logic [7:0]           cattr_reg, cattr_next;
    logic                 upd_reg, upd_next;
    logic                 last_reg, last_next;
    logic [ROW_W-1:0]     cur_row_reg;
    logic [COL_W-1:0]     cur_col_reg;

    logic [COL_W:0]       col_inc;
    logic                 at_end;
    logic                 tab_hit;
    logic [ROW_W-1:0]     row_inc;
    logic [TAB_CNT_W-1:0] tab_pre;
    logic                 tab_done;
    logic                 emit;

    // Next column, next row and the tab stop test
    always_comb
    begin
        col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
        at_end  = (col_inc >= COL_END);
        row_inc = (row_reg == ROW_LAST) ? ROW_LAST : row_reg + ROW_W'(1);
        tab_hit = 1'b0;
        for (int k = 1; k <= MAX_K; k++)
        begin
            if (col_inc == (COL_W + 1)'(k * TAB_STOP))
                tab_hit = 1'b1;
        end
        tab_pre  = cmd.first ? '0 : tab_cnt_reg;
        tab_done = tab_hit || at_end || (tab_pre == TAB_CNT_W'(TAB_MAX_CELLS - 1));
    end

    assign status.tab_done = tab_done;
    assign status.out_busy = out_valid_reg && out_stall;

    // Move the cursor and build the result word for one step
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        tab_cnt_next = tab_cnt_reg;
        emit         = 1'b0;
        wr_next      = 1'b0;
        crow_next    = '0;
        ccol_next    = '0;
        cchar_next   = '0;
        cattr_next   = '0;
        upd_next     = 1'b0;
        last_next    = 1'b1;
        if (cmd.step)
        begin
            case (cmd.op)
                OP_GOTO:
                begin
                    row_next = (goto_row > ROW_LAST) ? ROW_LAST : goto_row;
                    col_next = (goto_col > COL_LAST) ? COL_LAST : goto_col;
                    emit     = 1'b1;
                    upd_next = 1'b1;
                end
                OP_NEWLINE:
                begin
                    row_next = row_inc;
                    col_next = '0;
                    emit     = cmd.fin;
                    upd_next = 1'b1;
                end
                OP_CR:
                begin
                    col_next = '0;
                    emit     = cmd.fin;
                    upd_next = 1'b1;
                end
                OP_BS:
                begin
                    if (col_reg != '0)
                        col_next = col_reg - COL_W'(1);
                    emit     = cmd.fin;
                    upd_next = 1'b1;
                end
                OP_PRINT:
                begin
                    if (at_end)
                    begin
                        row_next = row_inc;
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                    emit       = 1'b1;
                    wr_next    = 1'b1;
                    crow_next  = row_reg;
                    ccol_next  = col_reg;
                    cchar_next = char_byte;
                    cattr_next = attr_reg;
                    upd_next   = cmd.fin;
                end
                OP_TAB:
                begin
                    if (at_end)
                    begin
                        row_next = row_inc;
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                    tab_cnt_next = tab_pre + TAB_CNT_W'(1);
                    emit         = 1'b1;
                    wr_next      = 1'b1;
                    crow_next    = row_reg;
                    ccol_next    = col_reg;
                    cchar_next   = CH_SPACE;
                    cattr_next   = attr_reg;
                    upd_next     = cmd.fin && tab_done;
                    last_next    = tab_done;
                end
                default:
                begin
                    emit     = cmd.fin;
                    upd_next = 1'b1;
                end
            endcase
        end
    end

    // Load the output word when a step emits one, drop it when taken
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        attr_next = cfg_wr_en ? cfg_wr_data : attr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            tab_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            attr_reg      <= attr_next;
            tab_cnt_reg   <= tab_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            wr_reg      <= wr_next;
            crow_reg    <= crow_next;
            ccol_reg    <= ccol_next;
            cchar_reg   <= cchar_next;
            cattr_reg   <= cattr_next;
            upd_reg     <= upd_next;
            last_reg    <= last_next;
            cur_row_reg <= row_next;
            cur_col_reg <= col_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_write    = wr_reg;
    assign cell_row      = crow_reg;
    assign cell_col      = ccol_reg;
    assign cell_char     = cchar_reg;
    assign cell_attr     = cattr_reg;
    assign cursor_update = upd_reg;
    assign cursor_row    = cur_row_reg;
    assign cursor_col    = cur_col_reg;
    assign last          = last_reg;

endmodule

### rtl/text_console_cursor_writer_top.sv
// A result word (if any) appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle for moves, control and printable bytes
// unless the output stalls; a tab writes one space cell per cycle (up to eight)
// unless the output stalls, and holds the input until its last cell is loaded.
// Reset (rst_n, asynchronous, active low): cursor at row 0 column 0,
// attribute 0x07, output empty.
module text_console_cursor_writer_top #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8,
    localparam int ROW_W   = $clog2(ROWS),
    localparam int COL_W   = $clog2(COLS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    input  logic [7:0]       char_byte,
    input  logic             final_in_string,
    input  logic [ROW_W-1:0] goto_row,
    input  logic [COL_W-1:0] goto_col,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             cell_write,
    output logic [ROW_W-1:0] cell_row,
    output logic [COL_W-1:0] cell_col,
    output logic [7:0]       cell_char,
    output logic [7:0]       cell_attr,
    output logic             cursor_update,
    output logic [ROW_W-1:0] cursor_row,
    output logic [COL_W-1:0] cursor_col,
    output logic             last
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .char_byte       (char_byte),
        .final_in_string (final_in_string),
        .status          (status),
        .cmd             (cmd)
    );

    tcw_datapath #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP),
        .ROW_W    (ROW_W),
        .COL_W    (COL_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .char_byte     (char_byte),
        .goto_row      (goto_row),
        .goto_col      (goto_col),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_write    (cell_write),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .cursor_update (cursor_update),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .last          (last)
    );

endmodule

### rtl/tcw_checker.sv
module tcw_checker #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int ROW_W    = $clog2(ROWS),
    parameter int COL_W    = $clog2(COLS)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             cell_write,
    input logic [ROW_W-1:0] cell_row,
    input logic [COL_W-1:0] cell_col,
    input logic [7:0]       cell_char,
    input logic [7:0]       cell_attr,
    input logic             cursor_update,
    input logic [ROW_W-1:0] cursor_row,
    input logic [COL_W-1:0] cursor_col,
    input logic             last
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_row) && $stable(cell_col)
            && $stable(cursor_row) && $stable(cursor_col) && $stable(last))
        else $error("stalled result word changed");

    // A word without a cell is a cursor report that closes its input
    a_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cell_write |-> cursor_update && last && cell_row == '0
            && cell_col == '0 && cell_char == 8'd0 && cell_attr == 8'd0)
        else $error("word without cell is malformed");

    // Cursor report only on the final word of an input
    a_upd_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cursor_update |-> last)
        else $error("cursor report before last word");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_row <= ROW_W'(ROWS - 1) && cursor_col <= COL_W'(COLS - 1))
        else $error("cursor off screen");

    // No input taken while the result register is blocked
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted with output blocked");

endmodule

bind text_console_cursor_writer_top tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (.*);

### sim/tb_text_console_cursor_writer_top.sv
`timescale 1ns / 100ps

module tb_text_console_cursor_writer_top;

    import tcw_pkg::*;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int TAB_STOP    = 8;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLS);
    localparam int RAND_WORDS  = 35;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 20000;

    // One input word as offered to the block
    typedef struct packed {
        logic             action;
        logic [7:0]       char_byte;
        logic             fin;
        logic [ROW_W-1:0] goto_row;
        logic [COL_W-1:0] goto_col;
    } char_word_t;

    // One result word coming out of the block
    typedef struct packed {
        logic             cell_write;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             cursor_update;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_col;
        logic             last;
    } cell_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    char_word_t       in_word = '0;
    logic             cfg_wr_en = 1'b0;
    logic [7:0]       cfg_wr_data = 8'd0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             cell_write;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             cursor_update;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             last;

    // Word queues and scoreboard state
    char_word_t   pending_words[$];
    cell_result_t expected_cells[$];
    bit           in_fire = 1'b0;
    int           err_count = 0;
    int           result_num = 0;

    // Shadow copy of the console state
    int           shadow_row = 0;
    int           shadow_col = 0;
    logic [7:0]   shadow_attr = ATTR_RESET;

    // Idle and hold-off control
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_go = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_cnt = 0;

    text_console_cursor_writer_top #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (in_word.action),
        .char_byte       (in_word.char_byte),
        .final_in_string (in_word.fin),
        .goto_row        (in_word.goto_row),
        .goto_col        (in_word.goto_col),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cell_write      (cell_write),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .cursor_update   (cursor_update),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .last            (last)
    );

    // Free-running clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] ERROR: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_num, name, got, want));
    endtask

    // Move the shadow cursor to column 0 of the next row, clamped at the bottom
    function automatic void shadow_next_row();
        shadow_col = 0;
        if (shadow_row + 1 >= ROWS)
            shadow_row = ROWS - 1;
        else
            shadow_row++;
    endfunction

    // Work out the cells and cursor reports that one word causes
    function automatic void predict_console_writes(input char_word_t w);
        cell_result_t r;
        cell_result_t res[$];
        int           k;
        r = '0;
        if (w.action)
        begin
            // Move: saturate and always report
            shadow_row = (w.goto_row > ROWS - 1) ? ROWS - 1 : int'(w.goto_row);
            shadow_col = (w.goto_col > COLS - 1) ? COLS - 1 : int'(w.goto_col);
            r.cursor_update = 1'b1;
            r.cursor_row    = ROW_W'(shadow_row);
            r.cursor_col    = COL_W'(shadow_col);
            r.last          = 1'b1;
            expected_cells.push_back(r);
            return;
        end
        if (w.char_byte == CH_LF)
        begin
            shadow_next_row();
        end
        else if (w.char_byte == CH_CR)
        begin
            shadow_col = 0;
        end
        else if (w.char_byte == CH_BS)
        begin
            if (shadow_col > 0)
                shadow_col--;
        end
        else if (w.char_byte == CH_TAB)
        begin
            // Fill spaces up to the next tab stop, wrap once at the end
            do
            begin
                r            = '0;
                r.cell_write = 1'b1;
                r.cell_row   = ROW_W'(shadow_row);
                r.cell_col   = COL_W'(shadow_col);
                r.cell_char  = CH_SPACE;
                r.cell_attr  = shadow_attr;
                shadow_col++;
                r.cursor_row = ROW_W'(shadow_row);
                r.cursor_col = COL_W'(shadow_col);
                res.push_back(r);
            end
            while ((shadow_col % TAB_STOP) != 0 && shadow_col < COLS &&
                   res.size() < TAB_MAX_CELLS);
            if (shadow_col >= COLS)
                shadow_next_row();
            k = res.size() - 1;
            res[k].cursor_row = ROW_W'(shadow_row);
            res[k].cursor_col = COL_W'(shadow_col);
        end
        else if (w.char_byte >= CH_SPACE && w.char_byte <= CH_LAST_PRINT)
        begin
            r.cell_write = 1'b1;
            r.cell_row   = ROW_W'(shadow_row);
            r.cell_col   = COL_W'(shadow_col);
            r.cell_char  = w.char_byte;
            r.cell_attr  = shadow_attr;
            shadow_col++;
            if (shadow_col >= COLS)
                shadow_next_row();
            r.cursor_row = ROW_W'(shadow_row);
            r.cursor_col = COL_W'(shadow_col);
            res.push_back(r);
        end
        // End of string: report the cursor on the last word
        if (w.fin)
        begin
            if (res.size() == 0)
            begin
                r               = '0;
                r.cursor_update = 1'b1;
                r.cursor_row    = ROW_W'(shadow_row);
                r.cursor_col    = COL_W'(shadow_col);
                res.push_back(r);
            end
            else
            begin
                res[res.size() - 1].cursor_update = 1'b1;
            end
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_cells.push_back(res[i]);
    endfunction

    // Sample both channels, predict on accept, check each result word
    always @(posedge clk)
    begin : sample_and_check
        cell_result_t want;
        in_fire = in_valid && !in_stall;
        if (in_fire)
            predict_console_writes(in_word);
        if (cfg_wr_en)
            shadow_attr = cfg_wr_data;
        if (out_valid && !out_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with nothing expected", result_num));
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("cell_write", cell_write, want.cell_write);
                check_field("cell_row", cell_row, want.cell_row);
                check_field("cell_col", cell_col, want.cell_col);
                check_field("cell_char", cell_char, want.cell_char);
                check_field("cell_attr", cell_attr, want.cell_attr);
                check_field("cursor_update", cursor_update, want.cursor_update);
                check_field("cursor_row", cursor_row, want.cursor_row);
                check_field("cursor_col", cursor_col, want.cursor_col);
                check_field("last", last, want.last);
            end
            result_num++;
        end
    end

    // Offer the next word once the current one is taken, with random gaps
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output at random; hold off for a long stretch once when asked
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt == HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_char(input int code, input bit fin);
        char_word_t w;
        w           = '0;
        w.char_byte = 8'(code);
        w.fin       = fin;
        w.goto_row  = ROW_W'($urandom_range(31));
        w.goto_col  = COL_W'($urandom_range(127));
        pending_words.push_back(w);
    endtask

    task automatic add_move(input int row, input int col, input bit fin);
        char_word_t w;
        w           = '0;
        w.action    = 1'b1;
        w.char_byte = 8'($urandom_range(255));
        w.fin       = fin;
        w.goto_row  = ROW_W'(row);
        w.goto_col  = COL_W'(col);
        pending_words.push_back(w);
    endtask

    // Mostly printable text and tabs, some control bytes, moves and junk
    function automatic char_word_t random_word();
        char_word_t w;
        int         pick;
        w.action    = 1'b0;
        w.char_byte = 8'($urandom_range(255));
        w.fin       = ($urandom_range(3) == 0);
        w.goto_row  = ROW_W'($urandom_range(31));
        w.goto_col  = COL_W'($urandom_range(127));
        pick        = $urandom_range(99);
        if (pick < 15)
            w.action = 1'b1;
        else if (pick < 55)
            w.char_byte = 8'($urandom_range(CH_LAST_PRINT, CH_SPACE));
        else if (pick < 67)
            w.char_byte = CH_TAB;
        else if (pick < 75)
            w.char_byte = CH_LF;
        else if (pick < 81)
            w.char_byte = CH_CR;
        else if (pick < 87)
            w.char_byte = CH_BS;
        return w;
    endfunction

    // Wait until every word is taken and every result has come back
    task automatic wait_for_drain();
        int cycles;
        cycles = 0;
        do
        begin
            @(negedge clk);
            cycles++;
        end
        while ((pending_words.size() != 0 || in_valid || expected_cells.size() != 0) &&
               cycles < DRAIN_LIMIT);
        if (expected_cells.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words with the reset attribute
        send_idle_pct  = 6;
        recv_stall_pct = 67;
        add_move(0, 0, 1'b0);
        add_char(65, 1'b0);
        add_char(CH_SPACE, 1'b0);
        add_char(CH_LAST_PRINT, 1'b1);
        add_char(128, 1'b0);
        add_char(255, 1'b1);
        add_char(0, 1'b0);
        add_char(31, 1'b1);
        add_char(CH_TAB, 1'b0);
        add_char(CH_BS, 1'b0);
        add_char(CH_CR, 1'b1);
        add_char(CH_BS, 1'b1);
        add_char(CH_TAB, 1'b1);
        add_move(31, 127, 1'b0);
        add_char(90, 1'b0);
        add_char(CH_LF, 1'b1);
        add_move(24, 72, 1'b1);
        add_char(CH_TAB, 1'b0);
        add_move(0, 79, 1'b0);
        add_char(120, 1'b1);
        add_move(5, 79, 1'b0);
        add_char(CH_TAB, 1'b1);
        add_char(CH_LF, 1'b0);
        add_move(21, 100, 1'b1);
        add_char(200, 1'b0);
        wait_for_drain();

        // Random phases with changing attribute and idle pattern
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
                write_attr(8'hFF);
            else if (ph == 1)
                write_attr(8'h00);
            else
                write_attr(8'($urandom_range(255)));
            @(posedge clk);
            send_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
            recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
            if (ph == 2)
                hold_go = 1'b1;
            for (int i = 0; i < RAND_WORDS; i++)
                pending_words.push_back(random_word());
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
